@@ sv/clsu_pkg.sv @@
// Shared types and codes for the cursor list store.
package clsu_pkg;

   // Width that holds any list position for the largest supported depth.
   localparam int MAX_POS_W = 11;

   // Operation codes carried in a request beat.
   localparam logic [3:0] OP_CLEAR    = 4'd0;
   localparam logic [3:0] OP_INSERT   = 4'd1;
   localparam logic [3:0] OP_APPEND   = 4'd2;
   localparam logic [3:0] OP_REMOVE   = 4'd3;
   localparam logic [3:0] OP_TO_START = 4'd4;
   localparam logic [3:0] OP_TO_END   = 4'd5;
   localparam logic [3:0] OP_PREV     = 4'd6;
   localparam logic [3:0] OP_NEXT     = 4'd7;
   localparam logic [3:0] OP_TO_POS   = 4'd8;
   localparam logic [3:0] OP_READ     = 4'd9;

   // Status codes returned in a response beat.
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_NOELEM = 2'd2;
   localparam logic [1:0] ST_RANGE  = 2'd3;

   // Command broadcast to every cell of the chain.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_APPEND,
      CELL_REMOVE
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type           cmd;
      logic [MAX_POS_W-1:0]   cursor;
      logic [MAX_POS_W-1:0]   count;
   } cell_ctrl_type;

   typedef struct packed {
      logic [3:0]  operation;
      logic [31:0] item_value;
      logic [5:0]  position;
   } req_type;

   typedef struct packed {
      logic [31:0] data_out;
      logic [5:0]  length;
      logic [5:0]  cursor;
      logic        at_end;
      logic [1:0]  status;
   } rsp_type;

endpackage

@@ sv/clsu_cell.sv @@
// One storage cell of the list chain: holds one word and shifts with its neighbors.
module clsu_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int INDEX      = 0
) (
   input  logic                    clock,
   input  clsu_pkg::cell_ctrl_type ctrl,
   input  logic [DATA_WIDTH-1:0]   new_word,
   input  logic [DATA_WIDTH-1:0]   left_word,
   input  logic [DATA_WIDTH-1:0]   right_word,
   output logic [DATA_WIDTH-1:0]   word_out,
   output logic [DATA_WIDTH-1:0]   cursor_word
);

   localparam logic [clsu_pkg::MAX_POS_W-1:0] IDX      = clsu_pkg::MAX_POS_W'(INDEX);
   localparam logic [clsu_pkg::MAX_POS_W-1:0] IDX_NEXT = clsu_pkg::MAX_POS_W'(INDEX + 1);

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;

   // Pick the next word from the new word, a neighbor, or keep the current one.
   always_comb begin
      word_in = word_ff;
      case (ctrl.cmd)
         clsu_pkg::CELL_INSERT: begin
            if (IDX == ctrl.cursor) begin
               word_in = new_word;
            end else if (IDX > ctrl.cursor && IDX <= ctrl.count) begin
               word_in = left_word;
            end
         end
         clsu_pkg::CELL_APPEND: begin
            if (IDX == ctrl.count) begin
               word_in = new_word;
            end
         end
         clsu_pkg::CELL_REMOVE: begin
            if (IDX >= ctrl.cursor && IDX_NEXT < ctrl.count) begin
               word_in = right_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   // The stored word has no reset; only written entries are ever read.
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   // The cell under the cursor offers its word; all others offer zero.
   assign word_out    = word_ff;
   assign cursor_word = (IDX == ctrl.cursor) ? word_ff : '0;

endmodule

@@ sv/cursor_list_store_unit.sv @@
// Top level of the cursor list store: control, counters and the cell chain.
// A response beat appears in the cycle after its request beat is taken.
// Throughput: one request beat per cycle; every cell shifts in parallel with its
// neighbors, so insert and remove move all entries at once; a held response stalls input.
// Reset: synchronous; clears length, cursor and the response valid, and sets
// capacity to 32. Stored words are not cleared and need no clearing pass.
module cursor_list_store_unit #(
   parameter int DEPTH      = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  clsu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output clsu_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [5:0]        csr_wr_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = clsu_pkg::MAX_POS_W;
   localparam logic [PW-1:0] DEPTH_X = PW'(DEPTH);

   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  cursor_ff, cursor_in;
   logic [5:0]     capacity_ff;
   logic           rsp_valid_ff;
   clsu_pkg::rsp_type rsp_ff, rsp_in;

   logic           accept;
   logic [PW-1:0]  count_x, cursor_x, cap_x, limit_x, pos_x, nxt_count_x, nxt_cursor_x;
   logic [1:0]     status;
   logic           take_data;
   clsu_pkg::cell_cmd_type cmd;
   clsu_pkg::cell_ctrl_type ctrl;
   logic [DATA_WIDTH-1:0] new_word;
   logic [DATA_WIDTH-1:0] rd_word;
   logic [DATA_WIDTH-1:0] cell_word [DEPTH];
   logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;

   assign count_x  = PW'(count_ff);
   assign cursor_x = PW'(cursor_ff);
   assign cap_x    = PW'(capacity_ff);
   assign limit_x  = (cap_x < DEPTH_X) ? cap_x : DEPTH_X;
   assign pos_x    = PW'(req_data.position);
   assign new_word = DATA_WIDTH'(req_data.item_value);

   // Decode the operation into new counters, a status and a chain command.
   always_comb begin
      nxt_count_x  = count_x;
      nxt_cursor_x = cursor_x;
      status       = clsu_pkg::ST_OK;
      take_data    = 1'b0;
      cmd          = clsu_pkg::CELL_HOLD;
      case (req_data.operation)
         clsu_pkg::OP_CLEAR: begin
            nxt_count_x  = '0;
            nxt_cursor_x = '0;
         end
         clsu_pkg::OP_INSERT: begin
            if (count_x >= limit_x || cursor_x > count_x) begin
               status = clsu_pkg::ST_FULL;
            end else begin
               cmd         = clsu_pkg::CELL_INSERT;
               nxt_count_x = count_x + 1'b1;
            end
         end
         clsu_pkg::OP_APPEND: begin
            if (count_x >= limit_x) begin
               status = clsu_pkg::ST_FULL;
            end else begin
               cmd         = clsu_pkg::CELL_APPEND;
               nxt_count_x = count_x + 1'b1;
            end
         end
         clsu_pkg::OP_REMOVE: begin
            if (cursor_x >= count_x) begin
               status = clsu_pkg::ST_NOELEM;
            end else begin
               cmd         = clsu_pkg::CELL_REMOVE;
               take_data   = 1'b1;
               nxt_count_x = count_x - 1'b1;
            end
         end
         clsu_pkg::OP_TO_START: begin
            nxt_cursor_x = '0;
         end
         clsu_pkg::OP_TO_END: begin
            nxt_cursor_x = count_x;
         end
         clsu_pkg::OP_PREV: begin
            if (cursor_x != '0) begin
               nxt_cursor_x = cursor_x - 1'b1;
            end
         end
         clsu_pkg::OP_NEXT: begin
            if (cursor_x < count_x) begin
               nxt_cursor_x = cursor_x + 1'b1;
            end
         end
         clsu_pkg::OP_TO_POS: begin
            if (pos_x > count_x) begin
               status = clsu_pkg::ST_RANGE;
            end else begin
               nxt_cursor_x = pos_x;
            end
         end
         clsu_pkg::OP_READ: begin
            if (cursor_x >= count_x) begin
               status = clsu_pkg::ST_NOELEM;
            end else begin
               take_data = 1'b1;
            end
         end
         default: begin
            status = clsu_pkg::ST_OK;
         end
      endcase
   end

   assign count_in  = CW'(nxt_count_x);
   assign cursor_in = CW'(nxt_cursor_x);

   // The chain only moves on an accepted beat.
   always_comb begin
      ctrl.cmd    = accept ? cmd : clsu_pkg::CELL_HOLD;
      ctrl.cursor = cursor_x;
      ctrl.count  = count_x;
   end

   // Row of cells; each takes its left or right neighbor's word on a shift.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w;
      logic [DATA_WIDTH-1:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_word[i+1];
      end
      clsu_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .INDEX      (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_word    (new_word),
         .left_word   (left_w),
         .right_word  (right_w),
         .word_out    (cell_word[i]),
         .cursor_word (cell_rd[i])
      );
   end

   // Gather the word under the cursor; only one cell offers a nonzero word.
   always_comb begin
      rd_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_word = rd_word | cell_rd[i];
      end
   end

   // Build the response beat from the state after the operation.
   always_comb begin
      rsp_in.data_out = take_data ? 32'(rd_word) : '0;
      rsp_in.length   = nxt_count_x[5:0];
      rsp_in.cursor   = nxt_cursor_x[5:0];
      rsp_in.at_end   = (nxt_count_x == nxt_cursor_x);
      rsp_in.status   = status;
   end

   // Counters, capacity register and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         capacity_ff  <= 6'd32;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (accept) begin
            count_ff     <= count_in;
            cursor_ff    <= cursor_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload of the response needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ sv/clsu_checker.sv @@
// Port-level checks for the cursor list store, bound to the top level.
module clsu_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input clsu_pkg::rsp_type rsp_data,
   input logic              rsp_valid,
   input logic              rsp_stall
);

   // A stalled response beat stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // Every accepted request beat yields a response beat in the next cycle.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

   // Failed operations never return data.
   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != clsu_pkg::ST_OK |-> rsp_data.data_out == '0)
      else $error("error response carries data");

   // A missing current element means the cursor sits at the end.
   a_noelem_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == clsu_pkg::ST_NOELEM |-> rsp_data.at_end)
      else $error("no-element status with cursor not at end");

   // Reset leaves no response pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind cursor_list_store_unit clsu_checker u_clsu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);

@@ sim/tb_cursor_list_store_unit.sv @@
// Testbench for the cursor list store: directed and random list commands against a predictor.
`timescale 1ns / 1ps

module tb_cursor_list_store_unit;

   localparam int LIST_DEPTH     = 32;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASES         = 6;

   // Tracks the list contents, length and cursor, and holds the responses still owed.
   class list_scoreboard;
      logic [31:0]       words [LIST_DEPTH];
      int                length_now;
      int                cursor_now;
      int                capacity_now;
      clsu_pkg::rsp_type expected_q [$];
      int                mismatches;
      int                checked;
      int                status_seen [4];

      function new();
         length_now   = 0;
         cursor_now   = 0;
         capacity_now = 32;
         mismatches   = 0;
         checked      = 0;
         foreach (status_seen[k]) status_seen[k] = 0;
      endfunction

      function void set_capacity(logic [5:0] value);
         capacity_now = int'(value);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Applies one accepted request beat to the list and queues the response it owes.
      function void note_request(clsu_pkg::req_type r);
         clsu_pkg::rsp_type e;
         int      limit;
         int      i;
         e        = '0;
         e.status = clsu_pkg::ST_OK;
         limit    = (capacity_now < LIST_DEPTH) ? capacity_now : LIST_DEPTH;
         case (r.operation)
            clsu_pkg::OP_CLEAR: begin
               length_now = 0;
               cursor_now = 0;
            end
            clsu_pkg::OP_INSERT: begin
               if (length_now >= limit || cursor_now > length_now) begin
                  e.status = clsu_pkg::ST_FULL;
               end else begin
                  for (i = length_now; i > cursor_now; i--) words[i] = words[i-1];
                  words[cursor_now] = r.item_value;
                  length_now++;
               end
            end
            clsu_pkg::OP_APPEND: begin
               if (length_now >= limit) begin
                  e.status = clsu_pkg::ST_FULL;
               end else begin
                  words[length_now] = r.item_value;
                  length_now++;
               end
            end
            clsu_pkg::OP_REMOVE: begin
               if (cursor_now >= length_now) begin
                  e.status = clsu_pkg::ST_NOELEM;
               end else begin
                  e.data_out = words[cursor_now];
                  for (i = cursor_now; i + 1 < length_now; i++) words[i] = words[i+1];
                  length_now--;
               end
            end
            clsu_pkg::OP_TO_START: cursor_now = 0;
            clsu_pkg::OP_TO_END:   cursor_now = length_now;
            clsu_pkg::OP_PREV:     if (cursor_now != 0) cursor_now--;
            clsu_pkg::OP_NEXT:     if (cursor_now < length_now) cursor_now++;
            clsu_pkg::OP_TO_POS: begin
               if (int'(r.position) > length_now) e.status = clsu_pkg::ST_RANGE;
               else cursor_now = int'(r.position);
            end
            clsu_pkg::OP_READ: begin
               if (cursor_now >= length_now) e.status = clsu_pkg::ST_NOELEM;
               else e.data_out = words[cursor_now];
            end
            default: ;
         endcase
         e.length = 6'(length_now);
         e.cursor = 6'(cursor_now);
         e.at_end = (cursor_now == length_now);
         expected_q.push_back(e);
      endfunction

      // Compares one accepted response beat with the oldest expectation.
      function void check_response(clsu_pkg::rsp_type got);
         clsu_pkg::rsp_type e;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: response beat with none expected: ",
                         "data %h len %0d cur %0d end %0d st %0d"},
                        $realtime, got.data_out, got.length, got.cursor, got.at_end,
                        got.status);
            return;
         end
         e = expected_q.pop_front();
         checked++;
         status_seen[got.status]++;
         if (got.data_out !== e.data_out || got.length !== e.length ||
             got.cursor !== e.cursor || got.at_end !== e.at_end || got.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: mismatch, expected data %h len %0d cur %0d end %0d st %0d",
                        $realtime, e.data_out, e.length, e.cursor, e.at_end, e.status);
               $display("                 got      data %h len %0d cur %0d end %0d st %0d",
                        got.data_out, got.length, got.cursor, got.at_end, got.status);
            end
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   clsu_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   clsu_pkg::rsp_type rsp_data;
   logic              csr_wr_en;
   logic [5:0]        csr_wr_data;

   list_scoreboard sb;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;
   int beats_sent    = 0;

   cursor_list_store_unit #(
      .DEPTH      (LIST_DEPTH),
      .DATA_WIDTH (32)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver: random stalls, or a counted hold-off when one is requested.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Monitor both channels and watch for a stuck handshake.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         if (req_valid && !req_stall) sb.note_request(req_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_cursor_list_store_unit NOT OK");
            $finish;
         end
      end
   end

   function automatic clsu_pkg::req_type list_cmd(logic [3:0] op, logic [31:0] value,
                                                  logic [5:0] pos);
      clsu_pkg::req_type r;
      r.operation  = op;
      r.item_value = value;
      r.position   = pos;
      return r;
   endfunction

   // Random command mix biased toward growth so the list reaches its limit.
   function automatic clsu_pkg::req_type random_list_cmd();
      int         pick;
      logic [3:0] op;
      logic [5:0] pos;
      pick = $urandom_range(99);
      if      (pick < 2)  op = clsu_pkg::OP_CLEAR;
      else if (pick < 20) op = clsu_pkg::OP_INSERT;
      else if (pick < 36) op = clsu_pkg::OP_APPEND;
      else if (pick < 51) op = clsu_pkg::OP_REMOVE;
      else if (pick < 56) op = clsu_pkg::OP_TO_START;
      else if (pick < 61) op = clsu_pkg::OP_TO_END;
      else if (pick < 69) op = clsu_pkg::OP_PREV;
      else if (pick < 77) op = clsu_pkg::OP_NEXT;
      else if (pick < 85) op = clsu_pkg::OP_TO_POS;
      else if (pick < 95) op = clsu_pkg::OP_READ;
      else                op = 4'($urandom_range(10, 15));
      if ($urandom_range(3) != 0) pos = 6'($urandom_range(0, 33));
      else pos = 6'($urandom_range(0, 63));
      return list_cmd(op, $urandom, pos);
   endfunction

   // Offers one request beat after a random gap and returns at the edge that takes it.
   task automatic send_req(input clsu_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   // Stops offering beats and waits until every owed response has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [5:0] value);
      drain();
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_capacity(value);
   endtask

   initial begin
      int phase_send  [PHASES];
      int phase_stall [PHASES];
      int phase_cap   [PHASES];
      int ph;

      phase_send  = '{0, 85, 0, 32, 0, 32};
      phase_stall = '{0, 0, 85, 32, 0, 32};
      phase_cap   = '{32, 9, 63, 3, 20, 1};
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty list at reset capacity: missing element, clamped moves, bad position, unused code.
      send_req(list_cmd(clsu_pkg::OP_READ, 32'h0, 6'd0));
      send_req(list_cmd(clsu_pkg::OP_REMOVE, 32'h0, 6'd0));
      send_req(list_cmd(clsu_pkg::OP_PREV, 32'h0, 6'd0));
      send_req(list_cmd(clsu_pkg::OP_NEXT, 32'h0, 6'd0));
      send_req(list_cmd(clsu_pkg::OP_TO_POS, 32'h0, 6'd63));
      send_req(list_cmd(4'hF, 32'hFFFF_FFFF, 6'd63));
      // Build a short list and take entries out of the middle.
      send_req(list_cmd(clsu_pkg::OP_APPEND, 32'hFFFF_FFFF, 6'd0));
      send_req(list_cmd(clsu_pkg::OP_APPEND, 32'h0000_0000, 6'd0));
      send_req(list_cmd(clsu_pkg::OP_INSERT, 32'h1234_5678, 6'd0));
      send_req(list_cmd(clsu_pkg::OP_NEXT, 32'h0, 6'd0));
      send_req(list_cmd(clsu_pkg::OP_READ, 32'h0, 6'd0));
      send_req(list_cmd(clsu_pkg::OP_TO_END, 32'h0, 6'd0));
      send_req(list_cmd(clsu_pkg::OP_INSERT, 32'hA5A5_5A5A, 6'd0));
      send_req(list_cmd(clsu_pkg::OP_PREV, 32'h0, 6'd0));
      send_req(list_cmd(clsu_pkg::OP_REMOVE, 32'h0, 6'd0));
      send_req(list_cmd(clsu_pkg::OP_TO_POS, 32'h0, 6'd1));
      send_req(list_cmd(clsu_pkg::OP_REMOVE, 32'h0, 6'd0));
      send_req(list_cmd(clsu_pkg::OP_TO_POS, 32'h0, 6'd3));
      send_req(list_cmd(clsu_pkg::OP_CLEAR, 32'h0, 6'd0));

      // Small capacity fills up; zero capacity refuses growth.
      write_capacity(6'd2);
      send_req(list_cmd(clsu_pkg::OP_APPEND, 32'h8000_0001, 6'd0));
      send_req(list_cmd(clsu_pkg::OP_APPEND, 32'h7FFF_FFFE, 6'd0));
      send_req(list_cmd(clsu_pkg::OP_INSERT, 32'h5555_AAAA, 6'd0));
      write_capacity(6'd0);
      send_req(list_cmd(clsu_pkg::OP_APPEND, 32'h1, 6'd0));
      // Capacity below the current length keeps the entries but refuses growth.
      write_capacity(6'd1);
      send_req(list_cmd(clsu_pkg::OP_INSERT, 32'h2, 6'd0));
      send_req(list_cmd(clsu_pkg::OP_REMOVE, 32'h0, 6'd0));
      send_req(list_cmd(clsu_pkg::OP_APPEND, 32'h3, 6'd0));

      // Random phases with different idling patterns and capacities.
      for (ph = 0; ph < PHASES; ph++) begin
         write_capacity((ph == PHASES - 1) ? 6'($urandom_range(1, 32)) : 6'(phase_cap[ph]));
         send_idle_pct = phase_send[ph];
         stall_pct     = phase_stall[ph];
         // Hold the receiver off while the sender keeps going, so the input backs up.
         if (ph == 4) hold_left = 60;
         repeat (88) send_req(random_list_cmd());
      end

      drain();
      repeat (4) @(posedge clock);

      $display("%0d request beats sent, %0d responses checked over %0d idling phases",
               beats_sent, sb.checked, PHASES);
      $display("statuses seen: ok %0d, full %0d, no element %0d, out of range %0d",
               sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
      if (sb.pending() != 0) $display("%0d responses never arrived", sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb_cursor_list_store_unit OK");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("tb_cursor_list_store_unit NOT OK");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/clsu_pkg.sv
sv/clsu_cell.sv
sv/cursor_list_store_unit.sv
sv/clsu_checker.sv
sim/tb_cursor_list_store_unit.sv
